// ----- src/ffha_pkg.sv -----
package ffha_pkg;

    localparam int MAX_SEGMENTS = 64;
    localparam int UNIT_BYTES   = 8;
    localparam int IDX_W        = $clog2(MAX_SEGMENTS);
    localparam int CNT_W        = $clog2(MAX_SEGMENTS + 1);
    localparam int LEN_W        = 21;
    localparam int SUM_W        = LEN_W + 1;
    localparam int UNIT_W       = $clog2(UNIT_BYTES);

    localparam logic [LEN_W-1:0] HEAP_LIMIT = LEN_W'(1048576);
    localparam logic [LEN_W-1:0] HEAP_RESET = LEN_W'(65536);

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_ZERO    = 3'd1;
    localparam logic [2:0] ST_NOFIT   = 3'd2;
    localparam logic [2:0] ST_FULL    = 3'd3;
    localparam logic [2:0] ST_OVERLAP = 3'd4;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic CFG_BASE  = 1'b0;
    localparam logic CFG_BYTES = 1'b1;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_INIT,
        OP_LOAD,
        OP_SCAN,
        OP_APPLY,
        OP_SHIFT,
        OP_DONE,
        OP_CLEAR
    } op_t;

    typedef struct packed {
        op_t op;
    } ctl_cmd_t;

    typedef struct packed {
        logic scan_done;
        logic shift_done;
        logic early_done;
        logic need_shift;
    } ctl_sts_t;

    function automatic logic [LEN_W-1:0] heap_len_of(input logic [LEN_W-1:0] b);
        logic [LEN_W-1:0] s;
        begin
            s = (b > HEAP_LIMIT) ? HEAP_LIMIT : b;
            heap_len_of = {s[LEN_W-1:UNIT_W], {UNIT_W{1'b0}}};
        end
    endfunction

endpackage

// ----- src/ffha_ctrl.sv -----
module ffha_ctrl
    import ffha_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_fire,
    input  logic     out_fire,
    input  logic     cfg_we,
    input  ctl_sts_t sts,
    output ctl_cmd_t cmd,
    output logic     busy,
    output logic     out_valid
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_APPLY = 3'd2;
    localparam logic [2:0] S_SHIFT = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;
    localparam logic [2:0] S_INIT  = 3'd5;

    logic [2:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        unique case (state_reg)
            S_INIT:
            begin
                // table entry 0 has no reset; load it once
                cmd.op     = cfg_we ? OP_INIT : OP_CLEAR;
                state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (cfg_we)
                begin
                    cmd.op = OP_INIT;
                end
                else if (in_fire)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (sts.early_done)
                begin
                    cmd.op     = OP_DONE;
                    state_next = S_OUT;
                end
                else if (sts.scan_done)
                begin
                    state_next = S_APPLY;
                end
                else
                begin
                    cmd.op = OP_SCAN;
                end
            end
            S_APPLY:
            begin
                cmd.op     = OP_APPLY;
                state_next = sts.need_shift ? S_SHIFT : S_OUT;
            end
            S_SHIFT:
            begin
                if (sts.shift_done)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    cmd.op = OP_SHIFT;
                end
            end
            S_OUT:
            begin
                if (out_fire)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy      = (state_reg != S_IDLE);
    assign out_valid = (state_reg == S_OUT);

    a_out_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT) |-> ($past(state_reg) == S_OUT || $past(state_reg) == S_SCAN
            || $past(state_reg) == S_APPLY || $past(state_reg) == S_SHIFT))
        else $error("result without work");
    a_idle_after_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && out_fire) |=> (state_reg == S_IDLE))
        else $error("no return to idle");
    a_load_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && in_fire && !cfg_we) |=> (state_reg == S_SCAN))
        else $error("load did not start scan");

endmodule

// ----- src/ffha_dp.sv -----
module ffha_dp
    import ffha_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  ctl_cmd_t    cmd,
    output ctl_sts_t    sts,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_command,
    input  logic [20:0] in_size,
    input  logic [31:0] in_block,
    output logic [31:0] res_address,
    output logic [2:0]  res_status
);

    // segment table, one entry read and one written per cycle
    logic [LEN_W-1:0] off_mem [MAX_SEGMENTS];
    logic [LEN_W-1:0] len_mem [MAX_SEGMENTS];

    logic [31:0]      base_reg;
    logic [LEN_W-1:0] bytes_reg;
    logic [LEN_W-1:0] heap_len_reg;
    logic [CNT_W-1:0] count_reg;

    logic             cmd_reg;
    logic [SUM_W-1:0] size_reg;
    logic [32:0]      foff_reg;     // block - base, bit 32 unused
    logic [CNT_W-1:0] pos_reg;      // scan pointer
    logic [LEN_W-1:0] prev_end_reg; // end of entry pos-1
    logic             have_prev_reg;
    logic [LEN_W-1:0] prev_len_reg;
    logic [IDX_W-1:0] rd_idx;
    logic [LEN_W-1:0] rd_off_reg, rd_len_reg;
    logic             rd_ok_reg;    // rd_*_reg hold entry pos_reg
    logic [CNT_W-1:0] sh_reg;       // shift pointer
    logic             sh_up_reg;    // insert (up) or remove (down)
    logic [CNT_W-1:0] hold_wr_idx_reg;
    logic [LEN_W-1:0] hold_off_reg, hold_len_reg;
    logic [2:0]       st_reg;
    logic [31:0]      addr_reg;
    logic             early_reg, scan_done_reg, need_shift_reg;

    logic [SUM_W-1:0] size_rnd;
    logic [LEN_W-1:0] heap_len_n;
    logic [SUM_W-1:0] end_w;
    logic [SUM_W-1:0] seg_end;
    logic             at_end;
    logic             hold_step;    // insert: held entry goes in this step
    logic             shift_fin;

    always_comb
    begin
        size_rnd = ((SUM_W'(in_size) + SUM_W'(UNIT_BYTES - 1)) >> UNIT_W) << UNIT_W;
        heap_len_n = heap_len_of((cfg_index == CFG_BYTES) ? cfg_data[LEN_W-1:0] : bytes_reg);
        end_w   = SUM_W'(foff_reg[LEN_W-1:0]) + size_reg;
        seg_end = SUM_W'(rd_off_reg) + SUM_W'(rd_len_reg);
        at_end  = (pos_reg == count_reg);
        hold_step = sh_up_reg && (sh_reg == hold_wr_idx_reg);
    end

    // read address: scan uses pos (pos+1 once rd_ok), shift uses source entry
    always_comb
    begin
        if (cmd.op == OP_SHIFT)
        begin
            rd_idx = sh_up_reg ? IDX_W'(sh_reg - CNT_W'(1)) : IDX_W'(sh_reg + CNT_W'(1));
        end
        else if (cmd.op == OP_SCAN && rd_ok_reg)
        begin
            rd_idx = IDX_W'(pos_reg + CNT_W'(1));
        end
        else
        begin
            rd_idx = IDX_W'(pos_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        rd_off_reg <= off_mem[rd_idx];
        rd_len_reg <= len_mem[rd_idx];
    end

    // table writes
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_INIT)
        begin
            off_mem[0] <= '0;
            len_mem[0] <= heap_len_n;
        end
        else if (cmd.op == OP_CLEAR)
        begin
            off_mem[0] <= '0;
            len_mem[0] <= heap_len_reg;
        end
        else if (cmd.op == OP_SHIFT && hold_step)
        begin
            off_mem[IDX_W'(sh_reg)] <= hold_off_reg;
            len_mem[IDX_W'(sh_reg)] <= hold_len_reg;
        end
        else if (cmd.op == OP_SHIFT && rd_ok_reg)
        begin
            off_mem[IDX_W'(sh_reg)] <= rd_off_reg;
            len_mem[IDX_W'(sh_reg)] <= rd_len_reg;
        end
        else if (cmd.op == OP_APPLY && !(need_shift_reg && sh_up_reg))
        begin
            off_mem[IDX_W'(hold_wr_idx_reg)] <= hold_off_reg;
            len_mem[IDX_W'(hold_wr_idx_reg)] <= hold_len_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg        <= '0;
            bytes_reg       <= HEAP_RESET;
            heap_len_reg    <= HEAP_RESET;
            count_reg       <= CNT_W'(1);
            cmd_reg         <= CMD_ALLOC;
            size_reg        <= '0;
            foff_reg        <= '0;
            pos_reg         <= '0;
            have_prev_reg   <= 1'b0;
            prev_end_reg    <= '0;
            prev_len_reg    <= '0;
            sh_reg          <= '0;
            sh_up_reg       <= 1'b0;
            hold_wr_idx_reg <= '0;
            hold_off_reg    <= '0;
            hold_len_reg    <= '0;
            addr_reg        <= '0;
            st_reg          <= ST_OK;
            early_reg       <= 1'b0;
            scan_done_reg   <= 1'b0;
            need_shift_reg  <= 1'b0;
            rd_ok_reg       <= 1'b0;
        end
        else
        begin
            unique case (cmd.op)
                OP_INIT:
                begin
                    if (cfg_index == CFG_BASE)
                    begin
                        base_reg <= cfg_data;
                    end
                    else
                    begin
                        bytes_reg <= cfg_data[LEN_W-1:0];
                    end
                    heap_len_reg <= heap_len_n;
                    count_reg    <= (heap_len_n != '0) ? CNT_W'(1) : '0;
                end
                OP_LOAD:
                begin
                    cmd_reg       <= in_command;
                    size_reg      <= size_rnd;
                    foff_reg      <= {1'b0, in_block - base_reg};
                    pos_reg       <= '0;
                    have_prev_reg <= 1'b0;
                    prev_end_reg  <= '0;
                    rd_ok_reg     <= 1'b0;
                    addr_reg      <= '0;
                    scan_done_reg <= 1'b0;
                    need_shift_reg <= 1'b0;
                    if (size_rnd == '0)
                    begin
                        early_reg <= 1'b1;
                        st_reg    <= ST_ZERO;
                    end
                    else
                    begin
                        early_reg <= 1'b0;
                        st_reg    <= ST_OK;
                    end
                end
                OP_SCAN:
                begin
                    rd_ok_reg <= 1'b1;
                    if (cmd_reg == CMD_ALLOC)
                    begin
                        if (!rd_ok_reg)
                        begin
                            if (at_end)
                            begin
                                early_reg <= 1'b1;
                                st_reg    <= ST_NOFIT;
                            end
                        end
                        else if (SUM_W'(rd_len_reg) >= size_reg)
                        begin
                            addr_reg        <= base_reg + 32'(rd_off_reg);
                            scan_done_reg   <= 1'b1;
                            hold_wr_idx_reg <= pos_reg;
                            hold_off_reg    <= rd_off_reg + size_reg[LEN_W-1:0];
                            hold_len_reg    <= rd_len_reg - size_reg[LEN_W-1:0];
                            if (SUM_W'(rd_len_reg) == size_reg)
                            begin
                                need_shift_reg <= 1'b1;
                                sh_up_reg      <= 1'b0;
                                sh_reg         <= pos_reg;
                            end
                        end
                        else if (pos_reg + CNT_W'(1) == count_reg)
                        begin
                            early_reg <= 1'b1;
                            st_reg    <= ST_NOFIT;
                        end
                        else
                        begin
                            pos_reg <= pos_reg + CNT_W'(1);
                        end
                    end
                    else
                    begin
                        // free: bounds check on first cycle
                        if (!rd_ok_reg && (foff_reg[31:0] > 32'(heap_len_reg)
                            || 33'(size_reg) > 33'(heap_len_reg) - foff_reg))
                        begin
                            early_reg <= 1'b1;
                            st_reg    <= ST_OVERLAP;
                        end
                        else if ((rd_ok_reg || at_end)
                            && (at_end || rd_off_reg >= foff_reg[LEN_W-1:0]))
                        begin
                            // pos found
                            if (have_prev_reg && prev_end_reg > foff_reg[LEN_W-1:0])
                            begin
                                early_reg <= 1'b1;
                                st_reg    <= ST_OVERLAP;
                            end
                            else if (!at_end && SUM_W'(rd_off_reg) < end_w)
                            begin
                                early_reg <= 1'b1;
                                st_reg    <= ST_OVERLAP;
                            end
                            else if (have_prev_reg && prev_end_reg == foff_reg[LEN_W-1:0])
                            begin
                                scan_done_reg   <= 1'b1;
                                hold_wr_idx_reg <= pos_reg - CNT_W'(1);
                                hold_off_reg    <= prev_end_reg - prev_len_reg;
                                if (!at_end && SUM_W'(rd_off_reg) == end_w)
                                begin
                                    hold_len_reg   <= prev_len_reg + size_reg[LEN_W-1:0]
                                                      + rd_len_reg;
                                    need_shift_reg <= 1'b1;
                                    sh_up_reg      <= 1'b0;
                                    sh_reg         <= pos_reg;
                                end
                                else
                                begin
                                    hold_len_reg <= prev_len_reg + size_reg[LEN_W-1:0];
                                end
                            end
                            else if (!at_end && SUM_W'(rd_off_reg) == end_w)
                            begin
                                scan_done_reg   <= 1'b1;
                                hold_wr_idx_reg <= pos_reg;
                                hold_off_reg    <= foff_reg[LEN_W-1:0];
                                hold_len_reg    <= rd_len_reg + size_reg[LEN_W-1:0];
                            end
                            else if (count_reg >= CNT_W'(MAX_SEGMENTS))
                            begin
                                early_reg <= 1'b1;
                                st_reg    <= ST_FULL;
                            end
                            else
                            begin
                                scan_done_reg   <= 1'b1;
                                hold_wr_idx_reg <= pos_reg;
                                hold_off_reg    <= foff_reg[LEN_W-1:0];
                                hold_len_reg    <= size_reg[LEN_W-1:0];
                                need_shift_reg  <= 1'b1;
                                sh_up_reg       <= 1'b1;
                                sh_reg          <= count_reg;
                            end
                        end
                        else if (rd_ok_reg)
                        begin
                            have_prev_reg <= 1'b1;
                            prev_end_reg  <= seg_end[LEN_W-1:0];
                            prev_len_reg  <= rd_len_reg;
                            pos_reg       <= pos_reg + CNT_W'(1);
                        end
                    end
                end
                OP_APPLY:
                begin
                    rd_ok_reg <= 1'b0;
                    if (need_shift_reg && sh_up_reg)
                    begin
                        count_reg <= count_reg + CNT_W'(1);
                    end
                    else if (need_shift_reg)
                    begin
                        count_reg <= count_reg - CNT_W'(1);
                    end
                end
                OP_SHIFT:
                begin
                    if (hold_step)
                    begin
                        sh_reg    <= sh_reg - CNT_W'(1);
                        rd_ok_reg <= 1'b0;
                    end
                    else if (rd_ok_reg)
                    begin
                        sh_reg    <= sh_up_reg ? sh_reg - CNT_W'(1) : sh_reg + CNT_W'(1);
                        rd_ok_reg <= 1'b0;
                    end
                    else
                    begin
                        rd_ok_reg <= 1'b1;
                    end
                end
                OP_DONE:
                begin
                    addr_reg <= '0;
                end
                OP_NONE:
                begin
                end
                default:
                begin
                end
            endcase
        end
    end

    // insert: apply leaves the slot alone; entries move up from the top,
    // then the held entry lands at pos and the pointer steps below it
    always_comb
    begin
        if (sh_up_reg)
        begin
            shift_fin = (CNT_W'(sh_reg + CNT_W'(1)) == hold_wr_idx_reg);
        end
        else
        begin
            shift_fin = (sh_reg + CNT_W'(1) >= count_reg + CNT_W'(1));
        end
    end

    always_comb
    begin
        sts.scan_done  = scan_done_reg;
        sts.early_done = early_reg;
        sts.need_shift = need_shift_reg;
        sts.shift_done = shift_fin;
    end

    assign res_address = (st_reg == ST_OK) ? addr_reg : '0;
    assign res_status  = st_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_SEGMENTS))
        else $error("segment count overflow");
    a_err_no_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg != ST_OK) |-> (res_address == '0))
        else $error("address on error");
    a_no_both: assert property (@(posedge clk) disable iff (!rst_n)
        !(early_reg && scan_done_reg))
        else $error("both done and error");

endmodule

// ----- src/first_fit_heap_allocator.sv -----
// First-fit heap allocator: keeps an address-ordered table of up to 64 free
// segments and serves allocate and free requests one at a time. After reset
// or any configuration write the table is one segment over the whole heap;
// (none if the heap rounds to zero); the first cycle after reset loads
// that entry, with in_stall high. A request scans the table one entry per
// cycle through the table memory's single read port, then may shift entries
// to open or close a slot, each shifted entry read before it is written. An
// insert at the front of a table holding 63 entries is the slowest request;
// the shift length sets the worst case.
// The result beat holds until taken; in_stall is high while a request is
// in flight and during a configuration write. Configuration is only
// written while idle.
module first_fit_heap_allocator
    import ffha_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        command,
    input  logic [20:0] size_bytes,
    input  logic [31:0] block_address,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] address,
    output logic [2:0]  status
);

    ctl_cmd_t cmd;
    ctl_sts_t sts;
    logic     busy;
    logic     in_fire, out_fire;

    assign in_stall = busy || cfg_we;
    assign in_fire  = in_valid && !in_stall;
    assign out_fire = out_valid && !out_stall;

    ffha_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_fire),
        .out_fire  (out_fire),
        .cfg_we    (cfg_we),
        .sts       (sts),
        .cmd       (cmd),
        .busy      (busy),
        .out_valid (out_valid)
    );

    ffha_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_command  (command),
        .in_size     (size_bytes),
        .in_block    (block_address),
        .res_address (address),
        .res_status  (status)
    );

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
    import ffha_pkg::*;

    // ---- clock and reset ----
    logic clk = 1'b0;
    logic rst_n = 1'b0;
    always #10 clk = ~clk;

    // ---- DUT hookup ----
    logic        cfg_we = 1'b0;
    logic        cfg_index = CFG_BASE;
    logic [31:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        command = CMD_ALLOC;
    logic [20:0] size_bytes = '0;
    logic [31:0] block_address = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [31:0] address;
    logic [2:0]  status;

    first_fit_heap_allocator dut (.*);

    typedef struct packed {
        logic        cmd;
        logic [20:0] size;
        logic [31:0] addr;
    } request_t;

    typedef struct packed {
        logic [31:0] addr;
        logic [2:0]  st;
    } answer_t;

    localparam int IDLE_LIMIT = 20000;

    // ---- predictor state: mirror of the free-segment table ----
    logic [31:0] mdl_base;
    logic [20:0] mdl_bytes;
    int unsigned mdl_len;
    int unsigned seg_off [MAX_SEGMENTS];
    int unsigned seg_size [MAX_SEGMENTS];
    int unsigned seg_cnt;

    request_t pending_reqs[$];
    answer_t  expected_answers[$];
    int errors = 0;
    int beats_in = 0, beats_out = 0;
    int n_status [5];
    int idle_cycles = 0;

    // Live allocations, used to build well-formed frees.
    logic [31:0] live_addr[$];
    int unsigned live_size[$];

    // Last accepted beat and what the predictor made of it.
    logic        in_taken = 1'b0;
    answer_t     pred;
    logic        last_alloc_ok = 1'b0;
    logic [31:0] last_alloc_addr = '0;

    function automatic void table_rebuild();
        mdl_len = heap_len_of(mdl_bytes);
        seg_off[0] = 0;
        seg_size[0] = mdl_len;
        seg_cnt = (mdl_len != 0) ? 1 : 0;
    endfunction

    function automatic void drop_entry(int unsigned p);
        for (int unsigned k = p; k + 1 < seg_cnt; k++)
        begin
            seg_off[k] = seg_off[k+1];
            seg_size[k] = seg_size[k+1];
        end
        seg_cnt--;
    endfunction

    function automatic logic [2:0] heap_free(int unsigned off, int unsigned sz);
        int unsigned p;
        int unsigned fin;
        bit jp, jn;
        p = 0;
        if (off > mdl_len || sz > mdl_len - off)
            return ST_OVERLAP;
        fin = off + sz;
        while (p < seg_cnt && seg_off[p] < off)
            p++;
        if (p > 0 && seg_off[p-1] + seg_size[p-1] > off)
            return ST_OVERLAP;
        if (p < seg_cnt && seg_off[p] < fin)
            return ST_OVERLAP;
        jp = p > 0 && seg_off[p-1] + seg_size[p-1] == off;
        jn = p < seg_cnt && seg_off[p] == fin;
        if (jp && jn)
        begin
            seg_size[p-1] += sz + seg_size[p];
            drop_entry(p);
        end
        else if (jp)
            seg_size[p-1] += sz;
        else if (jn)
        begin
            seg_off[p] = off;
            seg_size[p] += sz;
        end
        else
        begin
            if (seg_cnt >= MAX_SEGMENTS)
                return ST_FULL;
            for (int unsigned k = seg_cnt; k > p; k--)
            begin
                seg_off[k] = seg_off[k-1];
                seg_size[k] = seg_size[k-1];
            end
            seg_off[p] = off;
            seg_size[p] = sz;
            seg_cnt++;
        end
        return ST_OK;
    endfunction

    function automatic answer_t heap_predict(request_t r);
        answer_t a;
        int unsigned sz;
        sz = ((int'(r.size) + UNIT_BYTES - 1) / UNIT_BYTES) * UNIT_BYTES;
        a.addr = '0;
        a.st = ST_NOFIT;
        if (sz == 0)
            a.st = ST_ZERO;
        else if (r.cmd == CMD_ALLOC)
        begin
            for (int unsigned k = 0; k < seg_cnt; k++)
            begin
                if (seg_size[k] >= sz)
                begin
                    a.addr = mdl_base + seg_off[k];
                    a.st = ST_OK;
                    if (seg_size[k] == sz)
                        drop_entry(k);
                    else
                    begin
                        seg_off[k] += sz;
                        seg_size[k] -= sz;
                    end
                    break;
                end
            end
        end
        else
            a.st = heap_free(32'(r.addr - mdl_base), sz);
        if (a.st != ST_OK)
            a.addr = '0;
        return a;
    endfunction

    // ---- driver: bursts from the pending queue, random gaps ----
    int burst_left = 0;
    int gap_left = 0;
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || in_taken)
            begin
                // previous beat taken (or none up): pick next beat or a gap
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_reqs.size() > 0)
                begin
                    request_t r;
                    r = pending_reqs.pop_front();
                    in_valid <= 1'b1;
                    command <= r.cmd;
                    size_bytes <= r.size;
                    block_address <= r.addr;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(0, 12);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
                    end
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Prediction happens at acceptance, so the expected order matches beats.
    always @(posedge clk)
    begin
        in_taken = rst_n && in_valid && !in_stall;
        if (in_taken)
        begin
            pred = heap_predict({command, size_bytes, block_address});
            expected_answers.push_back(pred);
            last_alloc_ok = (command == CMD_ALLOC) && (pred.st == ST_OK);
            last_alloc_addr = pred.addr;
            beats_in++;
        end
    end

    // ---- receiver stall pattern: phases of free run, light and heavy stall ----
    int stall_phase = 0;
    always @(negedge clk)
    begin
        stall_phase = (stall_phase + 1) % 400;
        if (stall_phase < 120)
            out_stall <= 1'b0;
        else if (stall_phase < 260)
            out_stall <= ($urandom_range(0, 3) == 0);
        else
            out_stall <= ($urandom_range(0, 3) != 0);
    end

    // ---- monitor / checker ----
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            beats_out++;
            if (expected_answers.size() == 0)
            begin
                $error("unexpected result beat: address=%h status=%0d", address, status);
                errors++;
            end
            else
            begin
                answer_t e;
                e = expected_answers.pop_front();
                if (address !== e.addr)
                begin
                    $error("address: expected %h got %h", e.addr, address);
                    errors++;
                end
                if (status !== e.st)
                begin
                    $error("status: expected %0d got %0d", e.st, status);
                    errors++;
                end
                if (e.st <= ST_OVERLAP)
                    n_status[e.st]++;
            end
        end
    end

    // ---- watchdog: no beat accepted on either side for too long ----
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // ---- stimulus helpers ----
    task automatic push_req(logic c, logic [20:0] s, logic [31:0] a);
        pending_reqs.push_back({c, s, a});
    endtask

    // Wait until everything queued has been accepted and answered, then let
    // the block settle (frees that fail leave nothing pending, but be safe).
    task automatic drain();
        wait (pending_reqs.size() == 0 && !in_valid);
        wait (expected_answers.size() == 0);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_cfg(logic idx, logic [31:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_BASE)
            mdl_base = val;
        else
            mdl_bytes = val[20:0];
        table_rebuild();
        live_addr.delete();
        live_size.delete();
    endtask

    // The just-queued allocation is the last beat accepted once drained;
    // its predicted address is exact, so remember it for later frees.
    task automatic drain_one_alloc();
        request_t r;
        r = pending_reqs[$];
        drain();
        if (last_alloc_ok)
        begin
            live_addr.push_back(last_alloc_addr);
            live_size.push_back(((int'(r.size) + 7) / 8) * 8);
        end
    endtask

    // Random phase: mostly allocations and frees of live blocks, split into
    // pieces sometimes so holes and merges both happen; plus noise frees.
    task automatic random_phase(int n, int max_sz);
        int sel;
        int unsigned i, sz, piece;
        for (int k = 0; k < n; k++)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 45 || live_addr.size() == 0)
            begin
                sz = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2097151)
                                                   : $urandom_range(0, max_sz);
                push_req(CMD_ALLOC, sz[20:0], $urandom());
            end
            else if (sel < 85)
            begin
                i = $urandom_range(0, live_addr.size() - 1);
                sz = live_size[i];
                piece = ($urandom_range(0, 3) == 0 && sz > 8) ? 8 * $urandom_range(1, sz / 8 - 1)
                                                                : sz;
                push_req(CMD_FREE, piece[20:0], live_addr[i] + (sz - piece));
                if (piece == sz)
                begin
                    live_addr.delete(i);
                    live_size.delete(i);
                end
                else
                    live_size[i] = sz - piece;
            end
            else
                push_req(CMD_FREE, 21'($urandom_range(0, 2097151)),
                         ($urandom_range(0, 1)) ? $urandom() : mdl_base + $urandom_range(0, mdl_len));
            // keep allocations known: wait for each alloc result when it matters
            if (sel < 45)
            begin
                drain_one_alloc();
            end
        end
    endtask

    // ---- main sequence ----
    initial
    begin
        mdl_base = '0;
        mdl_bytes = HEAP_RESET;
        table_rebuild();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: zero size, extremes, no fit, exact fit, merges, overlaps.
        push_req(CMD_ALLOC, 21'd0, 32'h0);
        push_req(CMD_FREE, 21'd0, 32'hFFFF_FFFF);
        push_req(CMD_ALLOC, 21'h1F_FFFF, 32'hFFFF_FFFF);   // no fit
        push_req(CMD_ALLOC, 21'd1, 32'h0);                 // rounds to 8 at 0
        push_req(CMD_ALLOC, 21'd13, 32'h0);                // 16 at 8
        push_req(CMD_ALLOC, 21'd8, 32'h0);                 // 8 at 24
        push_req(CMD_FREE, 21'd5, 32'd8);                  // 8..16 freed
        push_req(CMD_FREE, 21'd8, 32'd0);                  // merge forward
        push_req(CMD_FREE, 21'd8, 32'd16);                 // merge backward
        push_req(CMD_FREE, 21'd8, 32'd24);                 // merge both sides
        push_req(CMD_FREE, 21'd8, 32'd4);                  // overlap
        push_req(CMD_FREE, 21'd8, 32'hFFFF_FFF8);          // outside heap
        push_req(CMD_ALLOC, 21'd65536, 32'h0);             // exact fit, table empty
        push_req(CMD_ALLOC, 21'd8, 32'h0);                 // no fit
        push_req(CMD_FREE, 21'd65536, 32'd0);
        push_req(CMD_FREE, 21'd4, 32'd65533);              // reaches past end
        drain();

        // Table full: fill with 8-byte blocks, free every other one; the
        // 65th and 66th holes find the table full, later frees fall outside the heap.
        write_cfg(CFG_BYTES, 32'd1056);
        for (int k = 0; k < 132; k++)
            push_req(CMD_ALLOC, 21'd8, 32'h0);
        for (int k = 0; k < 132; k++)
            push_req(CMD_FREE, 21'd8, 32'(16 * k));
        drain();

        write_cfg(CFG_BASE, 32'hFFFF_FFF8);   // addresses wrap
        write_cfg(CFG_BYTES, 32'd4096);
        random_phase(300, 300);
        drain();

        write_cfg(CFG_BASE, 32'h0000_1003);   // unaligned base
        write_cfg(CFG_BYTES, 32'd8);          // smallest heap
        random_phase(80, 16);
        drain();

        write_cfg(CFG_BYTES, 32'd5);          // rounds to empty table
        push_req(CMD_ALLOC, 21'd8, 32'h0);
        push_req(CMD_FREE, 21'd8, 32'h0000_1003);
        drain();

        write_cfg(CFG_BYTES, 32'h1F_FFFF);    // saturates to the limit
        write_cfg(CFG_BASE, 32'h8000_0000);
        random_phase(400, 200000);
        drain();

        write_cfg(CFG_BYTES, 32'd1048576);
        write_cfg(CFG_BASE, 32'h0);
        random_phase(600, 2048);
        drain();

        repeat (20) @(posedge clk);
        $display("Run covered %0d request beats, %0d result beats over several heap settings.",
                 beats_in, beats_out);
        $display("Status mix ok/zero/nofit/full/overlap: %0d/%0d/%0d/%0d/%0d",
                 n_status[0], n_status[1], n_status[2], n_status[3], n_status[4]);
        if (errors == 0 && expected_answers.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
